@@ rtl/core/xmea_pkg.sv @@
package xmea_pkg;

	localparam int unsigned WORD_W   = 64;
	localparam int unsigned GR_COUNT = 16;
	localparam int unsigned GR_IDX_W = $clog2(GR_COUNT);
	localparam int unsigned DISP_W   = 32;

	localparam logic [7:0] MODRM_MOD_MASK = 8'hc0;
	localparam logic [7:0] MODRM_REG_MASK = 8'h38;
	localparam logic [7:0] MODRM_RM_MASK  = 8'h07;

	localparam logic [GR_IDX_W-1:0] GR_BX = GR_IDX_W'(3);
	localparam logic [GR_IDX_W-1:0] GR_SP = GR_IDX_W'(4);
	localparam logic [GR_IDX_W-1:0] GR_BP = GR_IDX_W'(5);
	localparam logic [GR_IDX_W-1:0] GR_SI = GR_IDX_W'(6);
	localparam logic [GR_IDX_W-1:0] GR_DI = GR_IDX_W'(7);

	localparam logic [2:0] RM_SIB      = 3'd4;
	localparam logic [2:0] RM_DISP     = 3'd5;
	localparam logic [2:0] RM16_DIRECT = 3'd6;
	localparam logic [1:0] MOD_NODISP  = 2'd0;
	localparam logic [1:0] MOD_DISP8   = 2'd1;
	localparam logic [1:0] MOD_DISP32  = 2'd2;
	localparam logic [1:0] MOD_REG     = 2'd3;

	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_DECODE = 1'b1;

	localparam logic [1:0] ASZ_16 = 2'd0;
	localparam logic [1:0] ASZ_32 = 2'd1;

	typedef enum logic [1:0] {
		TR_16,
		TR_32,
		TR_64
	} trunc_t;

	typedef struct packed {
		logic                kind;
		logic [GR_IDX_W-1:0] write_index;
		logic [WORD_W-1:0]   write_value;
		logic [7:0]          modrm_byte;
		logic [7:0]          sib_byte;
		logic [DISP_W-1:0]   displacement;
		logic [3:0]          rex_bits;
		logic [1:0]          addr_size;
		logic                no_mod;
	} req_t;

	typedef struct packed {
		logic                is_register;
		logic [1:0]          mod_field;
		logic [GR_IDX_W-1:0] reg_number;
		logic [GR_IDX_W-1:0] rm_number;
		logic [WORD_W-1:0]   effective_address;
		logic                stack_segment;
		logic                pc_relative;
	} rsp_t;

	typedef struct packed {
		logic                is_register;
		logic [1:0]          mod_field;
		logic [GR_IDX_W-1:0] reg_number;
		logic [GR_IDX_W-1:0] rm_number;
		logic                use_a;
		logic                use_b;
		logic [1:0]          scale;
		logic [WORD_W-1:0]   disp;
		trunc_t              trunc;
		logic                stack_segment;
		logic                pc_relative;
	} dec_t;

endpackage

@@ rtl/core/xmea_ram.sv @@
module xmea_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/xmea_regfile.sv @@
module xmea_regfile (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            we,
	input  logic [xmea_pkg::GR_IDX_W-1:0]   waddr,
	input  logic [xmea_pkg::WORD_W-1:0]     wdata,
	input  logic                            re,
	input  logic [xmea_pkg::GR_IDX_W-1:0]   raddr_a,
	input  logic [xmea_pkg::GR_IDX_W-1:0]   raddr_b,
	output logic [xmea_pkg::WORD_W-1:0]     rdata_a,
	output logic [xmea_pkg::WORD_W-1:0]     rdata_b
);
	import xmea_pkg::*;

	logic [GR_COUNT-1:0] vld_q;
	logic                va_q;
	logic                vb_q;
	logic [WORD_W-1:0]   ram_a;
	logic [WORD_W-1:0]   ram_b;

	xmea_ram #(.WIDTH(WORD_W), .DEPTH(GR_COUNT)) u_ram_a (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr_a),
		.rdata (ram_a)
	);

	xmea_ram #(.WIDTH(WORD_W), .DEPTH(GR_COUNT)) u_ram_b (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr_b),
		.rdata (ram_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			va_q  <= 1'b0;
			vb_q  <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				va_q <= vld_q[raddr_a];
				vb_q <= vld_q[raddr_b];
			end
		end
	end

	assign rdata_a = va_q ? ram_a : '0;
	assign rdata_b = vb_q ? ram_b : '0;

endmodule

@@ rtl/core/xmea_decode.sv @@
module xmea_decode (
	input  xmea_pkg::req_t                  req,
	input  logic                            long_mode,
	output xmea_pkg::dec_t                  dec,
	output logic [xmea_pkg::GR_IDX_W-1:0]   raddr_a,
	output logic [xmea_pkg::GR_IDX_W-1:0]   raddr_b
);
	import xmea_pkg::*;

	logic [1:0]          mod;
	logic [2:0]          reg3;
	logic [2:0]          rm3;
	logic [GR_IDX_W-1:0] rm4;
	logic [GR_IDX_W-1:0] base;
	logic [GR_IDX_W-1:0] idx;
	logic                is_reg;
	logic [WORD_W-1:0]   d_s8;
	logic [WORD_W-1:0]   d_z16;
	logic [WORD_W-1:0]   d_s32;

	assign mod    = 2'((req.modrm_byte & MODRM_MOD_MASK) >> 6);
	assign reg3   = 3'((req.modrm_byte & MODRM_REG_MASK) >> 3);
	assign rm3    = 3'(req.modrm_byte & MODRM_RM_MASK);
	assign rm4    = {req.rex_bits[0], rm3};
	assign base   = {req.rex_bits[0], req.sib_byte[2:0]};
	assign idx    = {req.rex_bits[1], req.sib_byte[5:3]};
	assign is_reg = (mod == MOD_REG) || req.no_mod;
	assign d_s8   = {{(WORD_W-8){req.displacement[7]}}, req.displacement[7:0]};
	assign d_z16  = {{(WORD_W-16){1'b0}}, req.displacement[15:0]};
	assign d_s32  = {{(WORD_W-DISP_W){req.displacement[DISP_W-1]}}, req.displacement};

	always_comb begin
		dec             = '0;
		dec.trunc       = TR_64;
		dec.is_register = is_reg;
		dec.mod_field   = mod;
		dec.reg_number  = {req.rex_bits[2], reg3};
		dec.rm_number   = rm4;
		raddr_a         = GR_BX;
		raddr_b         = GR_SI;
		if (!is_reg) begin
			if (req.addr_size == ASZ_16) begin
				dec.trunc = TR_16;
				if (mod == MOD_DISP8) begin
					dec.disp = d_s8;
				end else if (mod == MOD_DISP32
					|| (mod == MOD_NODISP && rm3 == RM16_DIRECT)) begin
					dec.disp = d_z16;
				end
				unique case (rm3)
					3'd0: begin
						raddr_a = GR_BX; raddr_b = GR_SI;
						dec.use_a = 1'b1; dec.use_b = 1'b1;
					end
					3'd1: begin
						raddr_a = GR_BX; raddr_b = GR_DI;
						dec.use_a = 1'b1; dec.use_b = 1'b1;
					end
					3'd2: begin
						raddr_a = GR_BP; raddr_b = GR_SI;
						dec.use_a = 1'b1; dec.use_b = 1'b1;
						dec.stack_segment = 1'b1;
					end
					3'd3: begin
						raddr_a = GR_BP; raddr_b = GR_DI;
						dec.use_a = 1'b1; dec.use_b = 1'b1;
						dec.stack_segment = 1'b1;
					end
					3'd4: begin
						raddr_a = GR_SI; dec.use_a = 1'b1;
					end
					3'd5: begin
						raddr_a = GR_DI; dec.use_a = 1'b1;
					end
					3'd6: begin
						raddr_a = GR_BP;
						if (mod != MOD_NODISP) begin
							dec.use_a = 1'b1;
							dec.stack_segment = 1'b1;
						end
					end
					default: begin
						raddr_a = GR_BX; dec.use_a = 1'b1;
					end
				endcase
			end else begin
				dec.trunc = (req.addr_size == ASZ_32) ? TR_32 : TR_64;
				if (rm3 == RM_SIB) begin
					raddr_a   = base;
					raddr_b   = idx;
					dec.scale = req.sib_byte[7:6];
					dec.use_b = (idx != GR_SP);
					if (req.sib_byte[2:0] == RM_DISP && mod == MOD_NODISP) begin
						dec.disp = d_s32;
					end else begin
						dec.use_a         = 1'b1;
						dec.stack_segment = (base == GR_SP) || (base == GR_BP);
					end
				end else if (rm3 == RM_DISP && mod == MOD_NODISP) begin
					dec.disp        = d_s32;
					dec.pc_relative = long_mode;
				end else begin
					raddr_a           = rm4;
					dec.use_a         = 1'b1;
					dec.stack_segment = (rm4 == GR_SP) || (rm4 == GR_BP);
				end
				if (mod == MOD_DISP8) begin
					dec.disp = d_s8;
				end else if (mod == MOD_DISP32) begin
					dec.disp = d_s32;
				end
			end
		end
	end

endmodule

@@ rtl/core/xmea_agen.sv @@
module xmea_agen (
	input  xmea_pkg::dec_t               dec,
	input  logic [xmea_pkg::WORD_W-1:0]  rdata_a,
	input  logic [xmea_pkg::WORD_W-1:0]  rdata_b,
	output xmea_pkg::rsp_t               rsp
);
	import xmea_pkg::*;

	logic [WORD_W-1:0] opa;
	logic [WORD_W-1:0] opb;
	logic [WORD_W-1:0] sum;

	assign opa = dec.use_a ? rdata_a : '0;
	assign opb = dec.use_b ? (rdata_b << dec.scale) : '0;
	assign sum = opa + opb + dec.disp;

	always_comb begin
		rsp.is_register   = dec.is_register;
		rsp.mod_field     = dec.mod_field;
		rsp.reg_number    = dec.reg_number;
		rsp.rm_number     = dec.rm_number;
		rsp.stack_segment = dec.stack_segment;
		rsp.pc_relative   = dec.pc_relative;
		case (dec.trunc)
			TR_16:   rsp.effective_address = {{(WORD_W-16){1'b0}}, sum[15:0]};
			TR_32:   rsp.effective_address = {{(WORD_W-32){1'b0}}, sum[31:0]};
			default: rsp.effective_address = sum;
		endcase
	end

endmodule

@@ rtl/core/x86_modrm_effective_address.sv @@
// ModR/M and SIB effective-address generator with a 16 x 64-bit register file.
// Request channel (req_valid, req_stall, req_data): a beat with kind 0 writes
// general register write_index with write_value and yields no response; a beat
// with kind 1 decodes one addressing form and yields one response beat.
// Response channel (rsp_valid, rsp_stall, rsp_data): mod, reg and rm numbers,
// the register-operand flag, the effective address and segment / RIP flags.
// Configuration channel (cfg_valid, cfg_ready, cfg_data): writes long_mode;
// cfg_ready is always high. Write it only while no decode is in flight.
// At acceptance the register file, two copies of a synchronous RAM, is read
// and the decode stage is loaded; the three-operand add runs in the cycle
// after the read, and its result is registered into the response register,
// which drives rsp_valid.
// Throughput: one beat per cycle while rsp_stall stays low.
// Reset clears long_mode, the pipeline valids and the per-register valid bits,
// so every register reads zero until written; no clearing pass is needed.
// While rsp_stall is high the response holds; a decode already read waits in
// its stage and req_stall rises until the response is taken.
module x86_modrm_effective_address (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  xmea_pkg::req_t  req_data,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output xmea_pkg::rsp_t  rsp_data,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic            cfg_data
);
	import xmea_pkg::*;

	logic                long_mode_q;
	logic                s1_valid_q;
	dec_t                dec;
	dec_t                dec_s1;
	rsp_t                rsp_next;
	rsp_t                rsp_q;
	logic                rsp_valid_q;
	logic [GR_IDX_W-1:0] raddr_a;
	logic [GR_IDX_W-1:0] raddr_b;
	logic [WORD_W-1:0]   rdata_a;
	logic [WORD_W-1:0]   rdata_b;
	logic                s1_adv;
	logic                accept;
	logic                dec_acc;
	logic                wr_acc;

	assign cfg_ready = 1'b1;
	assign s1_adv    = s1_valid_q && (!rsp_valid_q || !rsp_stall);
	assign req_stall = s1_valid_q && !s1_adv;
	assign accept    = req_valid && !req_stall;
	assign dec_acc   = accept && (req_data.kind == KIND_DECODE);
	assign wr_acc    = accept && (req_data.kind == KIND_WRITE);

	xmea_decode u_decode (
		.req       (req_data),
		.long_mode (long_mode_q),
		.dec       (dec),
		.raddr_a   (raddr_a),
		.raddr_b   (raddr_b)
	);

	xmea_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (wr_acc),
		.waddr   (req_data.write_index),
		.wdata   (req_data.write_value),
		.re      (dec_acc),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	xmea_agen u_agen (
		.dec     (dec_s1),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b),
		.rsp     (rsp_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_mode_q <= 1'b0;
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				long_mode_q <= cfg_data;
			end
			if (dec_acc) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dec_acc) begin
			dec_s1 <= dec;
		end
		if (s1_adv) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

`ifndef SYNTHESIS
	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> rsp_valid_q)
		else $error("advanced decode did not reach the response register");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |=> s1_valid_q)
		else $error("stalled decode stage lost its beat");

	a_reg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.is_register |->
			rsp_q.effective_address == '0 && !rsp_q.stack_segment
			&& !rsp_q.pc_relative)
		else $error("register operand carries address fields");

	a_rip_long: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.pc_relative |-> long_mode_q && !rsp_q.is_register)
		else $error("RIP-relative flag outside long mode");
`endif

endmodule

@@ dv/x86_modrm_effective_address_tb.sv @@
`timescale 1ns / 100ps

import xmea_pkg::*;

localparam logic [GR_IDX_W-1:0] GR_R12 = GR_IDX_W'(12);
localparam logic [GR_IDX_W-1:0] GR_R13 = GR_IDX_W'(13);

localparam logic [1:0] ASZ_64   = 2'd2;
localparam logic [1:0] ASZ_WIDE = 2'd3;

typedef enum logic [2:0] {
	RM16_BX_SI,
	RM16_BX_DI,
	RM16_BP_SI,
	RM16_BP_DI,
	RM16_SI_ONLY,
	RM16_DI_ONLY,
	RM16_BP_ONLY,
	RM16_BX_ONLY
} rm16_t;

class ea_scoreboard;
	logic [WORD_W-1:0] regs [GR_COUNT];
	logic              long_mode;
	rsp_t              pending_ea [$];
	int                errors;

	function new();
		foreach (regs[i])
			regs[i] = '0;
		long_mode = 1'b0;
		errors = 0;
	endfunction

	function void set_long_mode(input logic v);
		long_mode = v;
	endfunction

	function void note_request(input req_t r);
		rsp_t              e;
		logic [1:0]        md;
		logic [2:0]        rm3;
		logic [3:0]        base;
		logic [3:0]        idx;
		logic [WORD_W-1:0] ea;
		logic [WORD_W-1:0] d8;
		logic [WORD_W-1:0] d32;
		if (r.kind == KIND_WRITE) begin
			regs[r.write_index] = r.write_value;
			return;
		end
		e = '0;
		ea = '0;
		md = r.modrm_byte[7:6];
		rm3 = r.modrm_byte[2:0];
		d8 = {{56{r.displacement[7]}}, r.displacement[7:0]};
		d32 = {{32{r.displacement[31]}}, r.displacement};
		e.mod_field = md;
		e.reg_number = {r.rex_bits[2], r.modrm_byte[5:3]};
		e.rm_number = {r.rex_bits[0], rm3};
		e.is_register = (md == MOD_REG) || r.no_mod;
		if (!e.is_register) begin
			if (r.addr_size == ASZ_16) begin
				if (md == MOD_DISP8)
					ea = d8;
				else if (md == MOD_DISP32 || (md == MOD_NODISP && rm3 == RM16_DIRECT))
					ea = {48'b0, r.displacement[15:0]};
				case (rm16_t'(rm3))
					RM16_BX_SI: ea += regs[GR_BX] + regs[GR_SI];
					RM16_BX_DI: ea += regs[GR_BX] + regs[GR_DI];
					RM16_BP_SI: begin
						ea += regs[GR_BP] + regs[GR_SI];
						e.stack_segment = 1'b1;
					end
					RM16_BP_DI: begin
						ea += regs[GR_BP] + regs[GR_DI];
						e.stack_segment = 1'b1;
					end
					RM16_SI_ONLY: ea += regs[GR_SI];
					RM16_DI_ONLY: ea += regs[GR_DI];
					RM16_BP_ONLY: begin
						if (md != MOD_NODISP) begin
							ea += regs[GR_BP];
							e.stack_segment = 1'b1;
						end
					end
					default: ea += regs[GR_BX];
				endcase
				ea = {48'b0, ea[15:0]};
			end else begin
				if (rm3 == RM_SIB) begin
					idx = {r.rex_bits[1], r.sib_byte[5:3]};
					base = {r.rex_bits[0], r.sib_byte[2:0]};
					if (base[2:0] == RM_DISP && md == MOD_NODISP)
						ea = d32;
					else begin
						ea = regs[base];
						e.stack_segment = (base == GR_SP) || (base == GR_BP);
					end
					if (idx != GR_SP)
						ea += regs[idx] << r.sib_byte[7:6];
				end else if (rm3 == RM_DISP && md == MOD_NODISP) begin
					ea = d32;
					e.pc_relative = long_mode;
				end else begin
					ea = regs[e.rm_number];
					e.stack_segment = (e.rm_number == GR_SP) || (e.rm_number == GR_BP);
				end
				if (md == MOD_DISP8)
					ea += d8;
				else if (md == MOD_DISP32)
					ea += d32;
				if (r.addr_size == ASZ_32)
					ea[63:32] = '0;
			end
		end
		e.effective_address = ea;
		pending_ea.push_back(e);
	endfunction

	task report(input string msg);
		$display("%0t: mismatch: %s", $realtime, msg);
		errors++;
	endtask

	task check_response(input rsp_t got);
		rsp_t e;
		if (pending_ea.size() == 0) begin
			report("response beat with no decode outstanding");
			return;
		end
		e = pending_ea.pop_front();
		if (got.is_register !== e.is_register)
			report($sformatf("is_register got %0b want %0b", got.is_register, e.is_register));
		if (got.mod_field !== e.mod_field)
			report($sformatf("mod_field got %0d want %0d", got.mod_field, e.mod_field));
		if (got.reg_number !== e.reg_number)
			report($sformatf("reg_number got %0d want %0d", got.reg_number, e.reg_number));
		if (got.rm_number !== e.rm_number)
			report($sformatf("rm_number got %0d want %0d", got.rm_number, e.rm_number));
		if (got.effective_address !== e.effective_address)
			report($sformatf("effective_address got %h want %h",
				got.effective_address, e.effective_address));
		if (got.stack_segment !== e.stack_segment)
			report($sformatf("stack_segment got %0b want %0b",
				got.stack_segment, e.stack_segment));
		if (got.pc_relative !== e.pc_relative)
			report($sformatf("pc_relative got %0b want %0b", got.pc_relative, e.pc_relative));
	endtask
endclass

module x86_modrm_effective_address_tb;

	localparam int IDLE_LIMIT   = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_ITEMS  = 250;
	localparam int CALM_ITEMS   = 100;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req_data;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp_data;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_data;

	ea_scoreboard sb = new();
	bit           calm = 1'b0;
	bit           hold_off = 1'b0;
	int           quiet_cycles = 0;

	x86_modrm_effective_address DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall)
				sb.check_response(rsp_data);
			if (req_valid && !req_stall)
				sb.note_request(req_data);
			if (cfg_valid && cfg_ready)
				sb.set_long_mode(cfg_data);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				hold_off = 1'b0;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	function automatic req_t write_reg(input logic [GR_IDX_W-1:0] idx,
		input logic [WORD_W-1:0] value);
		req_t r;
		r = '0;
		r.kind = KIND_WRITE;
		r.write_index = idx;
		r.write_value = value;
		return r;
	endfunction

	function automatic req_t decode(input logic [1:0] md, input logic [2:0] rg,
		input logic [2:0] rm, input logic [7:0] sib, input logic [31:0] disp,
		input logic [3:0] rex, input logic [1:0] asz, input logic nm);
		req_t r;
		r = '0;
		r.kind = KIND_DECODE;
		r.modrm_byte = {md, rg, rm};
		r.sib_byte = sib;
		r.displacement = disp;
		r.rex_bits = rex;
		r.addr_size = asz;
		r.no_mod = nm;
		return r;
	endfunction

	function automatic req_t random_item();
		req_t r;
		r.kind = ($urandom_range(0, 9) < 3) ? KIND_WRITE : KIND_DECODE;
		r.write_index = GR_IDX_W'($urandom_range(0, GR_COUNT - 1));
		case ($urandom_range(0, 4))
			0: r.write_value = '1;
			1: r.write_value = {32'b0, $urandom};
			2: r.write_value = {$urandom, 32'hffff_ffff};
			3: r.write_value = {16'h8000, 32'b0, 16'($urandom)};
			default: r.write_value = {$urandom, $urandom};
		endcase
		r.modrm_byte = 8'($urandom);
		r.sib_byte = 8'($urandom);
		r.displacement = $urandom;
		r.rex_bits = 4'($urandom);
		r.addr_size = 2'($urandom_range(0, 3));
		r.no_mod = ($urandom_range(0, 7) == 0);
		return r;
	endfunction

	task automatic send_beat(input req_t r);
		req_valid <= 1'b1;
		req_data <= r;
		do
			@(posedge clk);
		while (req_stall);
		if (!calm && $urandom_range(0, 11) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_ea.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_long_mode(input logic v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input int count, input logic last);
		for (int i = 0; i < count; i++) begin
			if (last && i == count - CALM_ITEMS)
				calm = 1'b1;
			send_beat(random_item());
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req_data <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_long_mode(1'b1);
		send_beat(write_reg(GR_BX, 64'hffff_ffff_ffff_fff0));
		send_beat(write_reg(GR_BP, 64'h8000_0000_0000_ffff));
		send_beat(write_reg(GR_SI, 64'h0000_0000_7fff_ffff));
		send_beat(write_reg(GR_DI, 64'hffff_ffff_0000_0001));
		send_beat(write_reg(GR_SP, 64'h1234_5678_9abc_def0));
		send_beat(write_reg(GR_R12, 64'hffff_ffff_ffff_ffff));
		send_beat(write_reg(GR_R13, 64'h0000_0001_0000_0000));
		send_beat(decode(MOD_REG, 3'd7, 3'd7, 8'hff, 32'hffff_ffff, 4'hf, ASZ_64, 1'b0));
		send_beat(decode(MOD_DISP32, 3'd0, RM_SIB, 8'h00, 32'h0, 4'h0, ASZ_32, 1'b1));
		send_beat(decode(MOD_NODISP, 3'd1, RM16_BX_SI, 8'h00, 32'hffff_ffff, 4'h0, ASZ_16, 1'b0));
		send_beat(decode(MOD_DISP8, 3'd2, RM16_BX_DI, 8'h00, 32'h0000_0080, 4'h0, ASZ_16, 1'b0));
		send_beat(decode(MOD_DISP32, 3'd3, RM16_BP_SI, 8'h00, 32'h0000_ffff, 4'h4, ASZ_16, 1'b0));
		send_beat(decode(MOD_NODISP, 3'd4, RM16_BP_DI, 8'h00, 32'h0, 4'h0, ASZ_16, 1'b0));
		send_beat(decode(MOD_DISP8, 3'd5, RM16_SI_ONLY, 8'h00, 32'h0000_007f, 4'h0, ASZ_16, 1'b0));
		send_beat(decode(MOD_DISP32, 3'd6, RM16_DI_ONLY, 8'h00, 32'h1234_8000, 4'h0, ASZ_16, 1'b0));
		send_beat(decode(MOD_NODISP, 3'd7, RM16_BP_ONLY, 8'h00, 32'habcd_ffff, 4'h0, ASZ_16, 1'b0));
		send_beat(decode(MOD_DISP8, 3'd0, RM16_BP_ONLY, 8'h00, 32'h0000_00ff, 4'h0, ASZ_16, 1'b0));
		send_beat(decode(MOD_NODISP, 3'd1, RM16_BX_ONLY, 8'h00, 32'h0, 4'h9, ASZ_16, 1'b0));
		send_beat(decode(MOD_NODISP, 3'd2, RM_SIB, {2'd3, 3'd4, 3'd5}, 32'h8000_0000, 4'h0,
			ASZ_32, 1'b0));
		send_beat(decode(MOD_DISP8, 3'd3, RM_SIB, {2'd3, 3'd4, 3'd4}, 32'h0000_0080, 4'h2,
			ASZ_64, 1'b0));
		send_beat(decode(MOD_NODISP, 3'd4, RM_SIB, {2'd1, 3'd6, 3'd5}, 32'h7fff_ffff, 4'h1,
			ASZ_64, 1'b0));
		send_beat(decode(MOD_DISP32, 3'd5, RM_SIB, {2'd2, 3'd7, 3'd5}, 32'hffff_fff0, 4'h8,
			ASZ_WIDE, 1'b0));
		send_beat(decode(MOD_NODISP, 3'd6, RM_DISP, 8'h00, 32'hffff_ffff, 4'h0, ASZ_64, 1'b0));
		send_beat(decode(MOD_DISP8, 3'd7, RM_DISP, 8'h00, 32'h0000_0001, 4'h0, ASZ_32, 1'b0));
		send_beat(decode(MOD_DISP8, 3'd0, RM_SIB, {2'd0, 3'd4, 3'd4}, 32'h0000_00f0, 4'h7,
			ASZ_64, 1'b0));
		send_beat(decode(MOD_DISP32, 3'd1, RM_DISP, 8'h00, 32'h8000_0000, 4'h5, ASZ_64, 1'b0));

		write_long_mode(1'b0);
		random_phase(PHASE_ITEMS, 1'b0);

		write_long_mode(1'b1);
		hold_off = 1'b1;
		random_phase(PHASE_ITEMS, 1'b0);

		write_long_mode(1'b0);
		random_phase(PHASE_ITEMS, 1'b1);

		drain();
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
